FILE: design/dtbs_pkg.sv
// Shared types and constants of the decision tree best split core.
// No dependencies; imported by every module of the block but dtbs_ram.
`default_nettype none

package dtbs_pkg;

  // Fixed field widths of the transaction ports
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned SIDX_W     = 8;
  localparam int unsigned FIDX_W     = 4;
  localparam int unsigned CIDX_W     = 3;
  localparam int unsigned WEIGHT_W   = 8;
  localparam int unsigned FEAT_OUT_W = 5;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned MIN_LEAF_W = 8;
  localparam int unsigned SCOUNT_W   = 9;
  localparam int unsigned FCOUNT_W   = 5;
  localparam int unsigned CCOUNT_W   = 4;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_LEAF      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FEATURE_COUNT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLASS_COUNT   = 2'd3;

  // Operation codes of an input transaction
  localparam logic [FUNC_W-1:0] FUNC_LOAD_FEAT   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_WEIGHT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RUN         = 2'd2;

  // Score arithmetic
  localparam int unsigned NUM_W  = 64;
  localparam int unsigned HALF_W = 32;

  typedef struct packed {
    logic load_feat;
    logic load_weight;
    logic run_start;
    logic tot_step;
    logic feat_start;
    logic sort_rd_vi;
    logic sort_latch_vi;
    logic sort_step;
    logic sort_wr;
    logic ord_rd;
    logic ord_latch;
    logic val_rd;
    logic val_latch;
    logic left_step;
    logic sq_clear;
    logic sq_step;
    logic mul1;
    logic mul2;
    logic cmp_lo;
    logic cmp_hi;
    logic decide;
    logic shift;
    logic out_load;
  } dtbs_cmd_t;

  typedef struct packed {
    logic differ;
    logic out_busy;
  } dtbs_sts_t;

endpackage

`default_nettype wire

FILE: design/dtbs_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none

module dtbs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: design/dtbs_datapath.sv
// Datapath of the best split core: sample stores, sort, class sums, scoring.
// Depends on dtbs_pkg and dtbs_ram; driven by dtbs_ctrl commands.
`default_nettype none

module dtbs_datapath #(
  parameter int unsigned MAX_SAMPLES  = 256,
  parameter int unsigned MAX_FEATURES = 16,
  parameter int unsigned MAX_CLASSES  = 8,
  localparam int unsigned NW  = $clog2(MAX_SAMPLES + 1),
  localparam int unsigned PW  = $clog2(MAX_FEATURES + 1),
  localparam int unsigned CNW = $clog2(MAX_CLASSES + 1)
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire dtbs_pkg::dtbs_cmd_t                 cmd_i,
  output dtbs_pkg::dtbs_sts_t                      sts_o,
  input  wire logic [PW-1:0]                       p_i,
  input  wire logic [NW-1:0]                       i_i,
  input  wire logic [NW-1:0]                       j_i,
  input  wire logic [NW-1:0]                       k_i,
  input  wire logic [CNW-1:0]                      c_i,
  input  wire logic [NW-1:0]                       n_i,
  input  wire logic [dtbs_pkg::SIDX_W-1:0]         sample_index_i,
  input  wire logic [dtbs_pkg::FIDX_W-1:0]         feature_index_i,
  input  wire logic [dtbs_pkg::CIDX_W-1:0]         class_index_i,
  input  wire logic signed [dtbs_pkg::VALUE_W-1:0] feature_value_i,
  input  wire logic [dtbs_pkg::WEIGHT_W-1:0]       class_weight_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic [dtbs_pkg::FEAT_OUT_W-1:0]          best_feature_o,
  output logic signed [dtbs_pkg::VALUE_W-1:0]      best_cut_o
);

  import dtbs_pkg::*;

  localparam int unsigned SW = $clog2(MAX_SAMPLES);
  localparam int unsigned FW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int unsigned CW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
  localparam int unsigned LW = NW + WEIGHT_W;
  localparam int unsigned QW = 2 * LW + CNW;
  localparam int unsigned PQ = QW + NW;
  localparam int unsigned DW = 2 * NW;
  localparam int unsigned HP = HALF_W + DW;
  localparam int unsigned FP = NUM_W + DW;

  // Memories
  logic [FW+SW-1:0]   fr_raddr;
  logic [VALUE_W-1:0] frd;
  logic               fr_we;
  logic [SW+CW-1:0]   wr_raddr;
  logic [WEIGHT_W-1:0] wrd;
  logic               wr_we;
  logic [SW-1:0]      ord_rd;

  logic [NW-1:0]      rank_q;
  logic [SW-1:0]      scur_q, sprev_q;
  logic [VALUE_W-1:0] vi_q, vcur_q, vprev_q;
  logic               greater;

  assign fr_we = cmd_i.load_feat && (32'(sample_index_i) < MAX_SAMPLES)
                 && (32'(feature_index_i) < MAX_FEATURES);
  assign wr_we = cmd_i.load_weight && (32'(sample_index_i) < MAX_SAMPLES)
                 && (32'(class_index_i) < MAX_CLASSES);

  always_comb begin
    if (cmd_i.sort_rd_vi) begin
      fr_raddr = {FW'(p_i), SW'(i_i)};
    end else if (cmd_i.val_rd) begin
      fr_raddr = {FW'(p_i), scur_q};
    end else begin
      fr_raddr = {FW'(p_i), SW'(j_i)};
    end
    if (cmd_i.tot_step) begin
      wr_raddr = {SW'(i_i), CW'(c_i)};
    end else begin
      wr_raddr = {sprev_q, CW'(c_i)};
    end
  end

  dtbs_ram #(.WIDTH(VALUE_W), .DEPTH(2 ** (FW + SW))) u_feat_ram (
    .clk_i   (clk_i),
    .we_i    (fr_we),
    .waddr_i ({FW'(feature_index_i), SW'(sample_index_i)}),
    .wdata_i (feature_value_i),
    .raddr_i (fr_raddr),
    .rdata_o (frd)
  );

  dtbs_ram #(.WIDTH(WEIGHT_W), .DEPTH(2 ** (SW + CW))) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (wr_we),
    .waddr_i ({SW'(sample_index_i), CW'(class_index_i)}),
    .wdata_i (class_weight_i),
    .raddr_i (wr_raddr),
    .rdata_o (wrd)
  );

  dtbs_ram #(.WIDTH(SW), .DEPTH(2 ** SW)) u_order_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.sort_wr),
    .waddr_i (SW'(rank_q)),
    .wdata_i (SW'(i_i)),
    .raddr_i (SW'(k_i)),
    .rdata_o (ord_rd)
  );

  // Pending flags for steps whose memory data lands in the next cycle
  logic          tot_pend_q, left_pend_q, rank_pend_q, found_q;
  logic [CW-1:0] c_dly_q;
  logic [NW-1:0] j_dly_q;
  logic          out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tot_pend_q  <= 1'b0;
      left_pend_q <= 1'b0;
      rank_pend_q <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      tot_pend_q  <= cmd_i.tot_step;
      left_pend_q <= cmd_i.left_step;
      rank_pend_q <= cmd_i.sort_step;
      if (cmd_i.run_start) begin
        found_q <= 1'b0;
      end else if (cmd_i.decide && greater) begin
        found_q <= 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Class sums
  logic [LW-1:0] tot_q  [MAX_CLASSES];
  logic [LW-1:0] left_q [MAX_CLASSES];
  logic [LW-1:0] lsel, rsel;
  logic [2*LW-1:0] lsq, rsq;

  assign lsel = left_q[CW'(c_i)];
  assign rsel = tot_q[CW'(c_i)] - left_q[CW'(c_i)];
  assign lsq  = (2*LW)'(lsel) * (2*LW)'(lsel);
  assign rsq  = (2*LW)'(rsel) * (2*LW)'(rsel);

  // Score registers
  logic [QW-1:0]    sl_q, sr_q;
  logic [PQ-1:0]    p1_q, p2_q;
  logic [NW-1:0]    nk;
  logic [DW-1:0]    den_q, bden_q;
  logic [NUM_W-1:0] num_q, bnum_q;
  logic [HP-1:0]    alo_q, ahi_q, blo_q, bhi_q;
  logic [FP-1:0]    afull, bfull;
  logic [PW-1:0]    bfeat_q;
  logic [VALUE_W-1:0] blo_val_q, bhi_val_q;
  logic [VALUE_W:0] msum;

  assign nk    = n_i - k_i;
  assign afull = {ahi_q, {HALF_W{1'b0}}} + FP'(alo_q);
  assign bfull = {bhi_q, {HALF_W{1'b0}}} + FP'(blo_q);
  assign greater = afull > bfull;
  assign msum  = {blo_val_q[VALUE_W-1], blo_val_q} + {bhi_val_q[VALUE_W-1], bhi_val_q};

  always_ff @(posedge clk_i) begin
    c_dly_q <= CW'(c_i);
    j_dly_q <= j_i;
    if (cmd_i.run_start) begin
      for (int x = 0; x < MAX_CLASSES; x++) begin
        tot_q[x] <= '0;
      end
    end else if (tot_pend_q) begin
      tot_q[c_dly_q] <= tot_q[c_dly_q] + LW'(wrd);
    end
    if (cmd_i.feat_start) begin
      for (int x = 0; x < MAX_CLASSES; x++) begin
        left_q[x] <= '0;
      end
    end else if (left_pend_q) begin
      left_q[c_dly_q] <= left_q[c_dly_q] + LW'(wrd);
    end
    // Rank of the held sample: smaller values, or equal values at lower index
    if (cmd_i.sort_latch_vi) begin
      vi_q   <= frd;
      rank_q <= '0;
    end else if (rank_pend_q) begin
      if (($signed(frd) < $signed(vi_q)) || ((frd == vi_q) && (j_dly_q < i_i))) begin
        rank_q <= rank_q + NW'(1);
      end
    end
    if (cmd_i.ord_latch) begin
      scur_q <= ord_rd;
    end
    if (cmd_i.val_latch) begin
      vcur_q <= frd;
    end
    if (cmd_i.shift) begin
      sprev_q <= scur_q;
      vprev_q <= vcur_q;
    end
    if (cmd_i.sq_clear) begin
      sl_q <= '0;
      sr_q <= '0;
    end else if (cmd_i.sq_step) begin
      sl_q <= sl_q + QW'(lsq);
      sr_q <= sr_q + QW'(rsq);
    end
    if (cmd_i.mul1) begin
      p1_q  <= PQ'(sl_q) * PQ'(nk);
      p2_q  <= PQ'(sr_q) * PQ'(k_i);
      den_q <= DW'(k_i) * DW'(nk);
    end
    if (cmd_i.mul2) begin
      num_q <= NUM_W'(p1_q) + NUM_W'(p2_q);
    end
    if (cmd_i.cmp_lo) begin
      alo_q <= HP'(num_q[HALF_W-1:0]) * HP'(bden_q);
      blo_q <= HP'(bnum_q[HALF_W-1:0]) * HP'(den_q);
    end
    if (cmd_i.cmp_hi) begin
      ahi_q <= HP'(num_q[NUM_W-1:HALF_W]) * HP'(bden_q);
      bhi_q <= HP'(bnum_q[NUM_W-1:HALF_W]) * HP'(den_q);
    end
    if (cmd_i.run_start) begin
      bnum_q  <= '0;
      bden_q  <= DW'(1);
      bfeat_q <= '0;
    end else if (cmd_i.decide && greater) begin
      bnum_q    <= num_q;
      bden_q    <= den_q;
      bfeat_q   <= p_i + PW'(1);
      blo_val_q <= vprev_q;
      bhi_val_q <= vcur_q;
    end
    if (cmd_i.out_load) begin
      if (found_q) begin
        best_feature_o <= FEAT_OUT_W'(bfeat_q);
        best_cut_o     <= msum[VALUE_W:1];
      end else begin
        best_feature_o <= '0;
        best_cut_o     <= '0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sts_o.differ    = (vcur_q != vprev_q);
  assign sts_o.out_busy  = out_valid_q && out_stall_i;

endmodule

`default_nettype wire

FILE: design/dtbs_ctrl.sv
// Controller of the best split core: configuration registers, sequencer, loop counters.
// Depends on dtbs_pkg; issues commands to dtbs_datapath.
`default_nettype none

module dtbs_ctrl #(
  parameter int unsigned MAX_SAMPLES  = 256,
  parameter int unsigned MAX_FEATURES = 16,
  parameter int unsigned MAX_CLASSES  = 8,
  localparam int unsigned NW  = $clog2(MAX_SAMPLES + 1),
  localparam int unsigned PW  = $clog2(MAX_FEATURES + 1),
  localparam int unsigned CNW = $clog2(MAX_CLASSES + 1)
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [dtbs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [dtbs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [dtbs_pkg::FUNC_W-1:0]     func_i,
  output dtbs_pkg::dtbs_cmd_t                  cmd_o,
  input  wire dtbs_pkg::dtbs_sts_t             sts_i,
  output logic [PW-1:0]                        p_o,
  output logic [NW-1:0]                        i_o,
  output logic [NW-1:0]                        j_o,
  output logic [NW-1:0]                        k_o,
  output logic [CNW-1:0]                       c_o,
  output logic [NW-1:0]                        n_o
);

  import dtbs_pkg::*;

  typedef enum logic [23:0] {
    S_IDLE       = 24'h000001,
    S_TOT        = 24'h000002,
    S_TOT_DRAIN  = 24'h000004,
    S_FEAT       = 24'h000008,
    S_SORT_VI    = 24'h000010,
    S_SORT_LATCH = 24'h000020,
    S_SORT_J     = 24'h000040,
    S_SORT_DRAIN = 24'h000080,
    S_SORT_WR    = 24'h000100,
    S_ORD        = 24'h000200,
    S_ORD_W      = 24'h000400,
    S_VAL        = 24'h000800,
    S_VAL_W      = 24'h001000,
    S_CHECK      = 24'h002000,
    S_LEFT       = 24'h004000,
    S_LEFT_DRAIN = 24'h008000,
    S_SQ         = 24'h010000,
    S_MUL1       = 24'h020000,
    S_MUL2       = 24'h040000,
    S_CMP_LO     = 24'h080000,
    S_CMP_HI     = 24'h100000,
    S_DECIDE     = 24'h200000,
    S_NEXT       = 24'h400000,
    S_DONE       = 24'h800000
  } state_e;

  state_e state_q, state_d;
  logic [MIN_LEAF_W-1:0] min_leaf_q;
  logic [SCOUNT_W-1:0]   sample_count_q;
  logic [FCOUNT_W-1:0]   feature_count_q;
  logic [CCOUNT_W-1:0]   class_count_q;
  logic [PW-1:0]  p_q, p_d;
  logic [NW-1:0]  i_q, i_d, j_q, j_d, k_q, k_d;
  logic [CNW-1:0] c_q, c_d;

  logic [NW-1:0]         n_eff;
  logic [PW-1:0]         nf_eff;
  logic [CNW-1:0]        nc_eff;
  logic [MIN_LEAF_W-1:0] ml_eff;
  logic i_last, j_last, c_last, k_last, p_last, in_window;

  assign n_eff  = (32'(sample_count_q) > MAX_SAMPLES) ? NW'(MAX_SAMPLES)
                                                      : NW'(sample_count_q);
  assign nf_eff = (32'(feature_count_q) > MAX_FEATURES) ? PW'(MAX_FEATURES)
                                                        : PW'(feature_count_q);
  assign nc_eff = (32'(class_count_q) > MAX_CLASSES) ? CNW'(MAX_CLASSES)
                                                     : CNW'(class_count_q);
  assign ml_eff = (min_leaf_q == '0) ? MIN_LEAF_W'(1) : min_leaf_q;

  assign i_last = (32'(i_q) + 1) >= 32'(n_eff);
  assign j_last = (32'(j_q) + 1) >= 32'(n_eff);
  assign k_last = (32'(k_q) + 1) >= 32'(n_eff);
  assign c_last = (32'(c_q) + 1) >= 32'(nc_eff);
  assign p_last = (32'(p_q) + 1) >= 32'(nf_eff);
  assign in_window = (32'(k_q) >= 32'(ml_eff))
                     && ((32'(k_q) + 32'(ml_eff)) <= 32'(n_eff));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      min_leaf_q      <= MIN_LEAF_W'(1);
      sample_count_q  <= SCOUNT_W'(256);
      feature_count_q <= FCOUNT_W'(16);
      class_count_q   <= CCOUNT_W'(8);
      p_q <= '0;
      i_q <= '0;
      j_q <= '0;
      k_q <= '0;
      c_q <= '0;
    end else begin
      state_q <= state_d;
      p_q <= p_d;
      i_q <= i_d;
      j_q <= j_d;
      k_q <= k_d;
      c_q <= c_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MIN_LEAF:      min_leaf_q      <= cfg_data_i[MIN_LEAF_W-1:0];
          REG_SAMPLE_COUNT:  sample_count_q  <= cfg_data_i[SCOUNT_W-1:0];
          REG_FEATURE_COUNT: feature_count_q <= cfg_data_i[FCOUNT_W-1:0];
          REG_CLASS_COUNT:   class_count_q   <= cfg_data_i[CCOUNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    state_d = state_q;
    p_d = p_q;
    i_d = i_q;
    j_d = j_q;
    k_d = k_q;
    c_d = c_q;
    cmd_o = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (func_i)
            FUNC_LOAD_FEAT:   cmd_o.load_feat = 1'b1;
            FUNC_LOAD_WEIGHT: cmd_o.load_weight = 1'b1;
            FUNC_RUN: begin
              cmd_o.run_start = 1'b1;
              p_d = '0;
              i_d = '0;
              c_d = '0;
              if ((32'(n_eff) < 2) || (nf_eff == '0) || (nc_eff == '0)) begin
                state_d = S_DONE;
              end else begin
                state_d = S_TOT;
              end
            end
            default: ;
          endcase
        end
      end
      S_TOT: begin
        cmd_o.tot_step = 1'b1;
        if (c_last) begin
          c_d = '0;
          if (i_last) begin
            state_d = S_TOT_DRAIN;
          end else begin
            i_d = i_q + NW'(1);
          end
        end else begin
          c_d = c_q + CNW'(1);
        end
      end
      S_TOT_DRAIN: state_d = S_FEAT;
      S_FEAT: begin
        cmd_o.feat_start = 1'b1;
        i_d = '0;
        state_d = S_SORT_VI;
      end
      S_SORT_VI: begin
        cmd_o.sort_rd_vi = 1'b1;
        state_d = S_SORT_LATCH;
      end
      S_SORT_LATCH: begin
        cmd_o.sort_latch_vi = 1'b1;
        j_d = '0;
        state_d = S_SORT_J;
      end
      S_SORT_J: begin
        cmd_o.sort_step = 1'b1;
        if (j_last) begin
          state_d = S_SORT_DRAIN;
        end else begin
          j_d = j_q + NW'(1);
        end
      end
      S_SORT_DRAIN: state_d = S_SORT_WR;
      S_SORT_WR: begin
        cmd_o.sort_wr = 1'b1;
        if (i_last) begin
          k_d = '0;
          state_d = S_ORD;
        end else begin
          i_d = i_q + NW'(1);
          state_d = S_SORT_VI;
        end
      end
      S_ORD: begin
        cmd_o.ord_rd = 1'b1;
        state_d = S_ORD_W;
      end
      S_ORD_W: begin
        cmd_o.ord_latch = 1'b1;
        state_d = S_VAL;
      end
      S_VAL: begin
        cmd_o.val_rd = 1'b1;
        state_d = S_VAL_W;
      end
      S_VAL_W: begin
        cmd_o.val_latch = 1'b1;
        state_d = (k_q == '0) ? S_NEXT : S_CHECK;
      end
      S_CHECK: begin
        if (in_window && sts_i.differ) begin
          cmd_o.sq_clear = 1'b1;
          c_d = '0;
          state_d = S_SQ;
        end else begin
          state_d = S_NEXT;
        end
      end
      S_SQ: begin
        cmd_o.sq_step = 1'b1;
        if (c_last) begin
          state_d = S_MUL1;
        end else begin
          c_d = c_q + CNW'(1);
        end
      end
      S_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d = S_CMP_LO;
      end
      S_CMP_LO: begin
        cmd_o.cmp_lo = 1'b1;
        state_d = S_CMP_HI;
      end
      S_CMP_HI: begin
        cmd_o.cmp_hi = 1'b1;
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d = S_NEXT;
      end
      S_NEXT: begin
        cmd_o.shift = 1'b1;
        if (!k_last) begin
          k_d = k_q + NW'(1);
          c_d = '0;
          state_d = S_LEFT;
        end else if (!p_last) begin
          p_d = p_q + PW'(1);
          state_d = S_FEAT;
        end else begin
          state_d = S_DONE;
        end
      end
      S_LEFT: begin
        cmd_o.left_step = 1'b1;
        if (c_last) begin
          state_d = S_LEFT_DRAIN;
        end else begin
          c_d = c_q + CNW'(1);
        end
      end
      S_LEFT_DRAIN: state_d = S_ORD;
      S_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign p_o = p_q;
  assign i_o = i_q;
  assign j_o = j_q;
  assign k_o = k_q;
  assign c_o = c_q;
  assign n_o = n_eff;

endmodule

`default_nettype wire

FILE: design/decision_tree_best_split_core.sv
// Best split search core (Gini criterion, exact integer scoring).
// Load transactions (feature value, class weight) are taken one per cycle, back to back, while idle.
// A run transaction ranks the n samples of each of f features, comparing every sample with
// every other over the single read port of the feature store, then scans the split positions.
// One result per run.
// Reset is asynchronous, active low: control clears, configuration returns to its defaults, stores stay undefined.
`default_nettype none

module decision_tree_best_split_core #(
  parameter int unsigned MAX_SAMPLES  = 256,
  parameter int unsigned MAX_FEATURES = 16,
  parameter int unsigned MAX_CLASSES  = 8
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [dtbs_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [dtbs_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [dtbs_pkg::FUNC_W-1:0]         func_i,
  input  wire logic [dtbs_pkg::SIDX_W-1:0]         sample_index_i,
  input  wire logic [dtbs_pkg::FIDX_W-1:0]         feature_index_i,
  input  wire logic [dtbs_pkg::CIDX_W-1:0]         class_index_i,
  input  wire logic signed [dtbs_pkg::VALUE_W-1:0] feature_value_i,
  input  wire logic [dtbs_pkg::WEIGHT_W-1:0]       class_weight_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic [dtbs_pkg::FEAT_OUT_W-1:0]          best_feature_o,
  output logic signed [dtbs_pkg::VALUE_W-1:0]      best_cut_o
);

  import dtbs_pkg::*;

  localparam int unsigned NW  = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned PW  = $clog2(MAX_FEATURES + 1);
  localparam int unsigned CNW = $clog2(MAX_CLASSES + 1);

  dtbs_cmd_t      cmd;
  dtbs_sts_t      sts;
  logic [PW-1:0]  p_idx;
  logic [NW-1:0]  i_idx, j_idx, k_idx, n_eff;
  logic [CNW-1:0] c_idx;

  // Sequencer: takes transactions only while idle, walks totals, sort and scan per feature
  dtbs_ctrl #(
    .MAX_SAMPLES  (MAX_SAMPLES),
    .MAX_FEATURES (MAX_FEATURES),
    .MAX_CLASSES  (MAX_CLASSES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .func_i     (func_i),
    .cmd_o      (cmd),
    .sts_i      (sts),
    .p_o        (p_idx),
    .i_o        (i_idx),
    .j_o        (j_idx),
    .k_o        (k_idx),
    .c_o        (c_idx),
    .n_o        (n_eff)
  );

  // Stores, class sums, score multipliers and the output register
  dtbs_datapath #(
    .MAX_SAMPLES  (MAX_SAMPLES),
    .MAX_FEATURES (MAX_FEATURES),
    .MAX_CLASSES  (MAX_CLASSES)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .p_i             (p_idx),
    .i_i             (i_idx),
    .j_i             (j_idx),
    .k_i             (k_idx),
    .c_i             (c_idx),
    .n_i             (n_eff),
    .sample_index_i  (sample_index_i),
    .feature_index_i (feature_index_i),
    .class_index_i   (class_index_i),
    .feature_value_i (feature_value_i),
    .class_weight_i  (class_weight_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .best_feature_o  (best_feature_o),
    .best_cut_o      (best_cut_o)
  );

  // A run transaction holds off the input side until its search is done
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && func_i == FUNC_RUN) |=> in_stall_o)
    else $error("input accepted right after a run transaction");

  // No split found means a zero cut
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && best_feature_o == '0) |-> (best_cut_o == '0))
    else $error("nonzero cut without a winning feature");

  // Winning feature never exceeds the feature capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(best_feature_o) <= MAX_FEATURES))
    else $error("winning feature out of range");

  // A load transaction never creates a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && func_i != FUNC_RUN && !out_valid_o) |=> !out_valid_o)
    else $error("result produced by a load transaction");

endmodule

`default_nettype wire

FILE: tb/decision_tree_best_split_core_test.sv
// Self-checking testbench for decision_tree_best_split_core: loads samples, runs split
// searches and compares each result against an in-bench Gini split predictor or a directed expected split.
// Depends on dtbs_pkg for port widths, register indexes and operation codes.
module decision_tree_best_split_core_test;
  import dtbs_pkg::*;

  localparam int unsigned N_SMP = 256;
  localparam int unsigned N_FEAT = 16;
  localparam int unsigned N_CLS = 8;
  localparam int unsigned ITEM_GOAL = 1650;
  localparam int unsigned RUN_GOAL = 45;
  localparam int unsigned SETTLE = 8;        // cycles a load may still be in flight
  localparam int unsigned HOLD_CYCLES = 4000; // long receiver hold-off
  localparam int unsigned WATCHDOG = 500000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic [FUNC_W-1:0] func;
  logic [SIDX_W-1:0] sample_index;
  logic [FIDX_W-1:0] feature_index;
  logic [CIDX_W-1:0] class_index;
  logic signed [VALUE_W-1:0] feature_value;
  logic [WEIGHT_W-1:0] class_weight;
  logic out_valid;
  logic out_stall;
  logic [FEAT_OUT_W-1:0] best_feature;
  logic signed [VALUE_W-1:0] best_cut;

  decision_tree_best_split_core uut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .func_i(func), .sample_index_i(sample_index), .feature_index_i(feature_index),
    .class_index_i(class_index), .feature_value_i(feature_value),
    .class_weight_i(class_weight),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .best_feature_o(best_feature), .best_cut_o(best_cut)
  );

  typedef struct {
    logic [FEAT_OUT_W-1:0] feat;
    logic signed [VALUE_W-1:0] cut;
  } split_t;

  // One directed stimulus row: a register write or a transaction
  typedef struct {
    bit is_cfg;
    bit has_exp;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DATA_W-1:0] data;
    logic [FUNC_W-1:0] fn;
    logic [SIDX_W-1:0] s;
    logic [FIDX_W-1:0] f;
    logic [CIDX_W-1:0] c;
    logic signed [VALUE_W-1:0] v;
    logic [WEIGHT_W-1:0] w;
    split_t want;
  } row_t;

  localparam logic [FUNC_W-1:0] FUNC_IDLE_CODE = 2'd3; // unused code, no effect

  // Shadow of the block: stores, written flags, register copies
  logic signed [VALUE_W-1:0] feat_mem [N_FEAT][N_SMP];
  byte unsigned wt_mem [N_SMP][N_CLS];
  bit feat_set [N_FEAT][N_SMP];
  bit wt_set [N_SMP][N_CLS];
  int unsigned sh_min_leaf, sh_samples, sh_features, sh_classes;

  split_t split_q[$];
  row_t dir_rows[$];
  int unsigned errors;
  int unsigned items_sent, runs_sent;
  int unsigned burst_left;
  int unsigned idle_cycles;
  bit hold_req;
  int unsigned hold_left;
  int unsigned rx_mode, rx_tick;

  // ---------------------------------------------------------------------------
  // Clock and reset
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    errors++;
    $display("MISMATCH: %s", what);
  endtask

  // ---------------------------------------------------------------------------
  // Predictor: exact Gini split search over the shadow stores
  // ---------------------------------------------------------------------------
  function automatic split_t gini_best_split();
    split_t res;
    int n, nf, nc, ml, bk, t, j, prev;
    int ord[N_SMP];
    longint unsigned tot[N_CLS], lft[N_CLS];
    longint unsigned bnum, bden, num, den, sl, sr, l, r;
    logic [127:0] p1, p2;
    logic signed [VALUE_W-1:0] a, b;
    bit won, found;
    n = (sh_samples > N_SMP) ? N_SMP : sh_samples;
    nf = (sh_features > N_FEAT) ? N_FEAT : sh_features;
    nc = (sh_classes > N_CLS) ? N_CLS : sh_classes;
    ml = (sh_min_leaf == 0) ? 1 : sh_min_leaf;
    bnum = 0;
    bden = 1;
    bk = 0;
    found = 0;
    res.feat = '0;
    res.cut = '0;
    for (int p = 0; p < nf; p++) begin
      won = 0;
      // stable insertion sort of sample order by this feature
      for (int i = 0; i < n; i++) ord[i] = i;
      for (int i = 1; i < n; i++) begin
        t = ord[i];
        j = i - 1;
        while (j >= 0 && feat_mem[p][ord[j]] > feat_mem[p][t]) begin
          ord[j+1] = ord[j];
          j--;
        end
        ord[j+1] = t;
      end
      for (int c = 0; c < nc; c++) begin
        tot[c] = 0;
        lft[c] = 0;
        for (int i = 0; i < n; i++) tot[c] += wt_mem[i][c];
      end
      for (int k = 1; k < n; k++) begin
        prev = ord[k-1];
        for (int c = 0; c < nc; c++) lft[c] += wt_mem[prev][c];
        if (k < ml || k > n - ml) continue;
        if (feat_mem[p][prev] == feat_mem[p][ord[k]]) continue;
        sl = 0;
        sr = 0;
        for (int c = 0; c < nc; c++) begin
          l = lft[c];
          r = tot[c] - lft[c];
          sl += l * l;
          sr += r * r;
        end
        num = sl * longint'(n - k) + sr * longint'(k);
        den = longint'(k) * longint'(n - k);
        p1 = {64'd0, num} * {64'd0, bden};
        p2 = {64'd0, bnum} * {64'd0, den};
        if (p1 > p2) begin
          bnum = num;
          bden = den;
          bk = k;
          res.feat = FEAT_OUT_W'(p + 1);
          won = 1;
          found = 1;
        end
      end
      if (won) begin
        a = feat_mem[p][ord[bk-1]];
        b = feat_mem[p][ord[bk]];
        res.cut = (a >>> 1) + (b >>> 1) + (a & b & 32'sd1);
      end
    end
    if (!found) begin
      res.feat = '0;
      res.cut = '0;
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $signed(($urandom_range(0, 7) - 3) * 65536); // few distinct values
      2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      3: return $urandom_range(0, 1) ? 32'sd0 : -32'sd1;
      default: return $signed($urandom_range(0, 40) << 14);
    endcase
  endfunction

  function automatic logic [WEIGHT_W-1:0] pick_weight();
    case ($urandom_range(0, 3))
      0: return 8'd0;
      1: return 8'd255;
      default: return WEIGHT_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Drive one transaction, idling in bursts, and update the shadow when it is taken
  task automatic send_txn(input row_t r);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    func <= r.fn;
    sample_index <= r.s;
    feature_index <= r.f;
    class_index <= r.c;
    feature_value <= r.v;
    class_weight <= r.w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    case (r.fn)
      FUNC_LOAD_FEAT: begin
        feat_mem[r.f][r.s] = r.v;
        feat_set[r.f][r.s] = 1;
      end
      FUNC_LOAD_WEIGHT: begin
        wt_mem[r.s][r.c] = r.w;
        wt_set[r.s][r.c] = 1;
      end
      FUNC_RUN: begin
        runs_sent++;
        if (r.has_exp) split_q.push_back(r.want);
        else split_q.push_back(gini_best_split());
      end
      default: ;
    endcase
  endtask

  function automatic row_t item_row(input logic [FUNC_W-1:0] fn, input int s, input int f,
                                    input int c, input logic signed [VALUE_W-1:0] v,
                                    input logic [WEIGHT_W-1:0] w);
    row_t r;
    r = '{default: '0};
    r.fn = fn;
    r.s = SIDX_W'(s);
    r.f = FIDX_W'(f);
    r.c = CIDX_W'(c);
    r.v = v;
    r.w = w;
    return r;
  endfunction

  function automatic row_t cfg_row(input logic [CFG_IDX_W-1:0] idx, input int data);
    row_t r;
    r = '{default: '0};
    r.is_cfg = 1;
    r.idx = idx;
    r.data = CFG_DATA_W'(data);
    return r;
  endfunction

  function automatic row_t run_row(input bit has_exp, input int ef, input int ec);
    row_t r;
    r = item_row(FUNC_RUN, $urandom, $urandom, $urandom, $urandom, WEIGHT_W'($urandom));
    r.has_exp = has_exp;
    r.want.feat = FEAT_OUT_W'(ef);
    r.want.cut = ec;
    return r;
  endfunction

  // Hold the input quiet until every result is back and loads have settled
  task automatic drain_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (split_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
    drain_block();
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= CFG_DATA_W'(data);
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MIN_LEAF: sh_min_leaf = data & 8'hff;
      REG_SAMPLE_COUNT: sh_samples = data & 9'h1ff;
      REG_FEATURE_COUNT: sh_features = data & 5'h1f;
      default: sh_classes = data & 4'hf;
    endcase
  endtask

  // Load every entry a run will read that has not been written yet, then run
  task automatic start_run(input row_t r);
    int n, nf, nc;
    n = (sh_samples > N_SMP) ? N_SMP : sh_samples;
    nf = (sh_features > N_FEAT) ? N_FEAT : sh_features;
    nc = (sh_classes > N_CLS) ? N_CLS : sh_classes;
    for (int i = 0; i < n; i++) begin
      for (int p = 0; p < nf; p++)
        if (!feat_set[p][i]) send_txn(item_row(FUNC_LOAD_FEAT, i, p, $urandom, pick_value(),
                                               WEIGHT_W'($urandom)));
      for (int c = 0; c < nc; c++)
        if (!wt_set[i][c]) send_txn(item_row(FUNC_LOAD_WEIGHT, i, $urandom, c, $urandom,
                                             pick_weight()));
    end
    send_txn(r);
  endtask

  task automatic set_config(input int ml, input int n, input int nf, input int nc);
    write_reg(REG_MIN_LEAF, ml);
    write_reg(REG_SAMPLE_COUNT, n);
    write_reg(REG_FEATURE_COUNT, nf);
    write_reg(REG_CLASS_COUNT, nc);
  endtask

  // ---------------------------------------------------------------------------
  // Main stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int n, nf, nc, loads, runs_here, phase;
    row_t r;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    func = '0;
    sample_index = '0;
    feature_index = '0;
    class_index = '0;
    feature_value = '0;
    class_weight = '0;
    errors = 0;
    items_sent = 0;
    runs_sent = 0;
    burst_left = 0;
    hold_req = 0;
    sh_min_leaf = 1;
    sh_samples = 256;
    sh_features = 16;
    sh_classes = 8;
    for (int p = 0; p < N_FEAT; p++)
      for (int i = 0; i < N_SMP; i++) feat_set[p][i] = 0;
    for (int i = 0; i < N_SMP; i++)
      for (int c = 0; c < N_CLS; c++) wt_set[i][c] = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: extremes, every code, the corner cases of the search
    dir_rows.push_back(cfg_row(REG_SAMPLE_COUNT, 4));
    dir_rows.push_back(cfg_row(REG_FEATURE_COUNT, 2));
    dir_rows.push_back(cfg_row(REG_CLASS_COUNT, 2));
    dir_rows.push_back(item_row(FUNC_LOAD_FEAT, 0, 0, 0, 32'sh7fffffff, 0));
    dir_rows.push_back(item_row(FUNC_LOAD_FEAT, 1, 0, 0, 32'sh80000000, 0));
    dir_rows.push_back(item_row(FUNC_LOAD_FEAT, 2, 0, 7, 32'sd0, 0));
    dir_rows.push_back(item_row(FUNC_LOAD_FEAT, 3, 0, 0, -32'sd1, 8'hff));
    dir_rows.push_back(item_row(FUNC_LOAD_WEIGHT, 0, 15, 0, 0, 8'd255));
    dir_rows.push_back(item_row(FUNC_LOAD_WEIGHT, 1, 0, 1, 0, 8'd0));
    dir_rows.push_back(run_row(0, 0, 0));
    dir_rows.push_back(item_row(FUNC_IDLE_CODE, 255, 15, 7, -32'sd1, 8'hff));
    dir_rows.push_back(cfg_row(REG_MIN_LEAF, 3));   // two leaves of 3 cannot fit in 4
    dir_rows.push_back(run_row(1, 0, 0));
    dir_rows.push_back(cfg_row(REG_MIN_LEAF, 0));   // zero acts as one
    dir_rows.push_back(run_row(0, 0, 0));
    dir_rows.push_back(cfg_row(REG_FEATURE_COUNT, 1));
    for (int i = 0; i < 4; i++)                    // all values equal: nothing qualifies
      dir_rows.push_back(item_row(FUNC_LOAD_FEAT, i, 0, 0, 32'sd5 << 16, 0));
    dir_rows.push_back(run_row(1, 0, 0));
    dir_rows.push_back(cfg_row(REG_FEATURE_COUNT, 0));
    dir_rows.push_back(run_row(1, 0, 0));
    dir_rows.push_back(cfg_row(REG_SAMPLE_COUNT, 1));
    dir_rows.push_back(run_row(1, 0, 0));

    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      if (r.is_cfg) write_reg(r.idx, r.data);
      else if (r.fn == FUNC_RUN) start_run(r);
      else send_txn(r);
    end
    set_config(1, 3, 2, 0);                        // no classes: score stays at zero
    start_run(run_row(1, 0, 0));

    // Random part: phases of well-formed load-and-run sequences with some noise
    phase = 0;
    while (items_sent < ITEM_GOAL || runs_sent < RUN_GOAL) begin
      phase++;
      case (phase)
        5: set_config(128, 511, 1, 1);   // saturated sample count, widest leaf
        17: set_config(0, 2, 31, 15);    // smallest set, saturated feature/class counts
        29: set_config(1, 64, 1, 8);
        default: set_config($urandom_range(0, 4), $urandom_range(2, 14),
                            $urandom_range(1, 4), $urandom_range(1, 4));
      endcase
      n = (sh_samples > N_SMP) ? N_SMP : sh_samples;
      nf = (sh_features > N_FEAT) ? N_FEAT : sh_features;
      nc = (sh_classes > N_CLS) ? N_CLS : sh_classes;
      runs_here = $urandom_range(1, 3);
      if (phase == 3) begin
        hold_req = 1;                            // stall output while runs pile up
        runs_here = 3;
      end
      for (int k = 0; k < runs_here; k++) begin
        loads = $urandom_range(0, 12);
        for (int j = 0; j < loads; j++) begin
          if ($urandom_range(0, 99) < 85) begin
            if ($urandom_range(0, 1))
              send_txn(item_row(FUNC_LOAD_FEAT, $urandom_range(0, n - 1),
                                $urandom_range(0, nf - 1), $urandom, pick_value(),
                                WEIGHT_W'($urandom)));
            else if (nc > 0)
              send_txn(item_row(FUNC_LOAD_WEIGHT, $urandom_range(0, n - 1), $urandom,
                                $urandom_range(0, nc - 1), $urandom, pick_weight()));
          end else if ($urandom_range(0, 1)) begin
            send_txn(item_row(FUNC_IDLE_CODE, $urandom, $urandom, $urandom, $urandom,
                              WEIGHT_W'($urandom)));
          end else begin
            send_txn(item_row(FUNC_W'($urandom_range(0, 1)), $urandom, $urandom, $urandom,
                              pick_value(), pick_weight()));
          end
        end
        start_run(run_row(0, 0, 0));
      end
      if (phase == 7) drain_block();             // sender pauses until all results are back
    end

    drain_block();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern picked at random among four modes, plus one long hold
  // ---------------------------------------------------------------------------
  initial begin
    out_stall = 1'b0;
    hold_left = 0;
    rx_mode = 0;
    rx_tick = 0;
    forever begin
      @(posedge clk);
      rx_tick++;
      if (rx_tick % 200 == 0) rx_mode = $urandom_range(0, 3);
      if (hold_req) begin
        hold_req = 0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (rx_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= 1'($urandom_range(0, 1));
          2: out_stall <= (rx_tick % 5) < 3;
          default: out_stall <= ($urandom_range(0, 9) < 8);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result check and watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    split_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (split_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: feature %0d cut %h",
                                  best_feature, best_cut));
      end else begin
        want = split_q.pop_front();
        if (best_feature !== want.feat)
          report_mismatch($sformatf("best_feature %0d, expected %0d", best_feature,
                                    want.feat));
        if (best_cut !== want.cut)
          report_mismatch($sformatf("best_cut %h, expected %h", best_cut, want.cut));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
